/* rtl/core/cdfs_pkg.sv */
// Shared types and constants for the discrete CDF sampler.
// Used by the top level and by the serial divider; depends on nothing.
package cdfs_pkg;

  // Table geometry and field widths.
  localparam int MAX_ENTRIES = 256;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 9;
  localparam int WEIGHT_W    = 16;
  localparam int SUM_W       = 24;
  localparam int FRAC_W      = 16;
  localparam int STATUS_W    = 2;

  // Largest value the running sum may hold.
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Status codes of a result beat.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLAMP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd2;

  // Item mode codes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // One input beat.
  typedef struct packed {
    logic                mode;
    logic [ENTRY_AW-1:0] weight_index;
    logic [WEIGHT_W-1:0] weight_value;
    logic [SUM_W-1:0]    random_value;
  } cdfs_in_t;

  // One result beat.
  typedef struct packed {
    logic [ENTRY_AW-1:0] sampled_index;
    logic [FRAC_W-1:0]   rescaled_fraction;
    logic [STATUS_W-1:0] status;
  } cdfs_out_t;

endpackage

/* rtl/core/cdfs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the cumulative weight table of the sampler.
module cdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/cdfs_div.sv */
// Bit-serial restoring divider producing FRAC_W+1 quotient bits of (n << FRAC_W) / d.
// Requires n <= d on start. Depends on cdfs_pkg.
module cdfs_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cdfs_pkg::SUM_W-1:0]      numer,
  input  logic [cdfs_pkg::SUM_W-1:0]      denom,
  output logic                            done,
  output logic [cdfs_pkg::FRAC_W:0]       quot
);
  import cdfs_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W + 2);

  logic [SUM_W:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]  den_r, den_nxt;
  logic [FRAC_W:0]   quot_r, quot_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;
  logic [SUM_W:0]    diff;

  // One quotient bit per cycle: compare, subtract if it fits, shift.
  always_comb begin
    ge       = rem_r >= {1'b0, den_r};
    diff     = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, numer};
      den_nxt  = denom;
      cnt_nxt  = STEP_W'(FRAC_W + 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[FRAC_W-1:0], ge};
      rem_nxt  = {diff[SUM_W-1:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

`ifndef SYNTH
  // The owner must wait for the previous division to finish.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  // A busy divider always has steps left.
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider busy with no steps left");
  // Completion follows the last step of a running division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("divider done without a division");
`endif

endmodule

/* rtl/core/discrete_cdf_sampler_core.sv */
// Discrete sampler by inverse CDF. A load beat stores the running sum of weights
// (index 0 restarts it, the sum saturates at 2^24-1). A sample beat scans the table
// entries in order and, when the chosen interval needs a division, then waits on the
// divider: the table is read one entry per cycle through the single RAM read port,
// and the fraction comes from a divider that yields one bit per cycle. Depends on
// cdfs_pkg, cdfs_ram and cdfs_div.
module discrete_cdf_sampler_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cdfs_pkg::cdfs_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cdfs_pkg::cdfs_out_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cdfs_pkg::CNT_W-1:0]   cfg_data
);
  import cdfs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_DONE} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    entries_r, entries_nxt;
  logic [SUM_W-1:0]    running_sum_r, running_sum_nxt;
  logic [SUM_W-1:0]    rand_r, rand_nxt;
  logic [SUM_W-1:0]    prev_r, prev_nxt;
  logic [ENTRY_AW-1:0] idx_r, idx_nxt;
  logic [ENTRY_AW-1:0] last_r, last_nxt;
  cdfs_out_t           res_r, res_nxt;
  cdfs_out_t           out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_acc;
  logic                load_acc;
  logic                samp_acc;
  logic [SUM_W:0]      load_sum;
  logic [SUM_W-1:0]    load_sat;
  logic [ENTRY_AW-1:0] rd_addr;
  logic [SUM_W-1:0]    rd_data;
  logic                div_start;
  logic                div_done;
  logic [FRAC_W:0]     div_quot;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (in_data.mode == MODE_LOAD);
  assign samp_acc  = in_acc && (in_data.mode == MODE_SAMPLE);

  // Running sum for a load beat, saturated.
  always_comb begin
    load_sum = ((in_data.weight_index == '0) ? '0 : {1'b0, running_sum_r}) +
               (SUM_W + 1)'(in_data.weight_value);
    load_sat = load_sum[SUM_W] ? SUM_MAX : load_sum[SUM_W-1:0];
  end

  // The scan fetches the next entry while the current one is compared.
  assign rd_addr = (state_r == ST_SCAN) ? idx_r + 1'b1 : '0;

  cdfs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (load_acc),
    .waddr (in_data.weight_index),
    .wdata (load_sat),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cdfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (rand_r - prev_r),
    .denom (rd_data - prev_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer: scan the table, divide if needed, then hand the result to the output.
  always_comb begin
    state_nxt       = state_r;
    entries_nxt     = entries_r;
    running_sum_nxt = running_sum_r;
    rand_nxt        = rand_r;
    prev_nxt        = prev_r;
    idx_nxt         = idx_r;
    last_nxt        = last_r;
    res_nxt         = res_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r;
    div_start       = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      entries_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (load_acc) begin
          running_sum_nxt = load_sat;
        end
        if (samp_acc) begin
          rand_nxt = in_data.random_value;
          prev_nxt = '0;
          idx_nxt  = '0;
          if (entries_r == '0) begin
            last_nxt = '0;
          end else if (entries_r > CNT_W'(MAX_ENTRIES)) begin
            last_nxt = ENTRY_AW'(MAX_ENTRIES - 1);
          end else begin
            last_nxt = ENTRY_AW'(entries_r - 1'b1);
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        res_nxt.sampled_index = idx_r;
        if (rd_data >= rand_r) begin
          if (rd_data <= prev_r) begin
            res_nxt.rescaled_fraction = '0;
            res_nxt.status            = STATUS_ZERO;
            state_nxt                 = ST_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end else if (idx_r == last_r) begin
          res_nxt.rescaled_fraction = '1;
          res_nxt.status            = STATUS_CLAMP;
          state_nxt                 = ST_DONE;
        end else begin
          prev_nxt = rd_data;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt.rescaled_fraction = div_quot[FRAC_W] ? '1 : div_quot[FRAC_W-1:0];
          res_nxt.status            = STATUS_OK;
          state_nxt                 = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entries_r     <= CNT_W'(1);
      running_sum_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entries_r     <= entries_nxt;
      running_sum_r <= running_sum_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    rand_r     <= rand_nxt;
    prev_r     <= prev_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A new result beat appears only when a finished sample is handed over.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result beat without a finished sample");
  // The scan never walks past the last entry in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= last_r)) else $error("scan beyond last entry");
  // Divider completion is only seen while waiting for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV)) else $error("division finished outside wait");
  // Waiting on the divider ends only with a finished result.
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV || state_r == ST_DONE))
    else $error("division wait left without result");
`endif

endmodule

/* tb/tb_discrete_cdf_sampler_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for discrete_cdf_sampler_core: weight loads, sample draws and
// search-length writes, with random idling on both channels. Depends on cdfs_pkg and the RTL.
module tb_discrete_cdf_sampler_core;
  import cdfs_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int PHASE_COUNT  = 8;
  localparam int HALF_ITEMS   = 45;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  cdfs_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cdfs_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data  = '0;

  // Beats waiting to be sent and draws waiting to come back.
  cdfs_in_t             pending_beats[$];
  cdfs_out_t            expected_draws[$];

  // Predictor state: cumulative weights, running sum and the search length.
  logic [SUM_W-1:0]     cum_weight[MAX_ENTRIES];
  logic [SUM_W-1:0]     weight_sum = '0;
  logic [CNT_W-1:0]     search_len = CNT_W'(1);

  // Stimulus-side view of the table, used only to aim the random values.
  logic [SUM_W-1:0]     plan_cum[MAX_ENTRIES];
  logic [SUM_W-1:0]     plan_sum = '0;
  logic                 plan_written[MAX_ENTRIES];

  int                   send_idle_pct = 0;
  int                   stall_pct     = 0;
  int                   error_count   = 0;
  int                   cycle_count   = 0;
  logic                 in_taken      = 1'b0;

  discrete_cdf_sampler_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Zero counts as one entry and anything past the table counts as the whole table.
  function automatic int clamp_search_len(input logic [CNT_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_ENTRIES) return MAX_ENTRIES;
    return n;
  endfunction

  // Expected effect of one accepted input beat.
  task automatic predict_beat(input cdfs_in_t beat);
    logic [SUM_W:0]    sum_next;
    logic [63:0]       lower, upper, quot;
    cdfs_out_t         draw;
    int                n;
    int                pick;
    bit                found;
    if (beat.mode == MODE_LOAD) begin
      // Index 0 restarts the sum; the sum saturates.
      sum_next = (beat.weight_index == 0) ? beat.weight_value : weight_sum + beat.weight_value;
      if (sum_next > SUM_MAX) sum_next = SUM_MAX;
      weight_sum = sum_next[SUM_W-1:0];
      cum_weight[beat.weight_index] = sum_next[SUM_W-1:0];
    end else begin
      // First in-use entry at or above the value, else the last one.
      n = clamp_search_len(search_len);
      found = 1'b0;
      pick = n - 1;
      for (int i = 0; i < n; i++) begin
        if (!found && cum_weight[i] >= beat.random_value) begin
          found = 1'b1;
          pick = i;
        end
      end
      lower = (pick > 0) ? cum_weight[pick-1] : 0;
      upper = cum_weight[pick];
      draw.sampled_index = ENTRY_AW'(pick);
      if (!found) begin
        draw.rescaled_fraction = '1;
        draw.status = STATUS_CLAMP;
      end else if (upper <= lower) begin
        draw.rescaled_fraction = '0;
        draw.status = STATUS_ZERO;
      end else begin
        quot = ((beat.random_value - lower) << FRAC_W) / (upper - lower);
        if (quot > {FRAC_W{1'b1}}) quot = {FRAC_W{1'b1}};
        draw.rescaled_fraction = quot[FRAC_W-1:0];
        draw.status = STATUS_OK;
      end
      expected_draws.push_back(draw);
    end
  endtask

  // Compare one result beat with the oldest expected draw.
  task automatic check_draw(input cdfs_out_t got);
    cdfs_out_t want;
    if (expected_draws.size() == 0) begin
      $error("result beat with nothing expected: index %0d", got.sampled_index);
      error_count++;
    end else begin
      want = expected_draws.pop_front();
      if (got.sampled_index !== want.sampled_index) begin
        $error("sampled_index: expected %0d, got %0d", want.sampled_index, got.sampled_index);
        error_count++;
      end
      if (got.rescaled_fraction !== want.rescaled_fraction) begin
        $error("rescaled_fraction: expected %0d, got %0d",
               want.rescaled_fraction, got.rescaled_fraction);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
    end
  endtask

  // Monitor: sample both handshakes at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      in_taken <= rst_n && in_valid && !in_stall;
      if (rst_n && in_valid && !in_stall) predict_beat(in_data);
      if (rst_n && out_valid && !out_stall) check_draw(out_data);
    end
  end

  // Driver: present the next beat and the stall at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 25) return '1;
    if (sel < 60) return WEIGHT_W'($urandom_range(1, 255));
    return WEIGHT_W'($urandom);
  endfunction

  task automatic queue_load(input logic [ENTRY_AW-1:0] idx, input logic [WEIGHT_W-1:0] w);
    cdfs_in_t       beat;
    logic [SUM_W:0] s;
    beat.mode         = MODE_LOAD;
    beat.weight_index = idx;
    beat.weight_value = w;
    beat.random_value = SUM_W'($urandom);
    s = (idx == 0) ? w : plan_sum + w;
    if (s > SUM_MAX) s = SUM_MAX;
    plan_sum = s[SUM_W-1:0];
    plan_cum[idx] = s[SUM_W-1:0];
    plan_written[idx] = 1'b1;
    pending_beats.push_back(beat);
  endtask

  task automatic queue_draw(input logic [SUM_W-1:0] r);
    cdfs_in_t beat;
    beat.mode         = MODE_SAMPLE;
    beat.weight_index = ENTRY_AW'($urandom);
    beat.weight_value = WEIGHT_W'($urandom);
    beat.random_value = r;
    pending_beats.push_back(beat);
  endtask

  // Mostly draws aimed at the table, plus short restarted reloads and stray loads.
  task automatic queue_random_items(input int count, input int eff);
    int              sel, k, len;
    int unsigned     span, r;
    for (int j = 0; j < count; j++) begin
      sel = $urandom_range(99);
      if (sel < 78) begin
        k = $urandom_range(eff - 1);
        span = plan_cum[eff-1] + plan_cum[eff-1] / 8 + 1;
        sel = $urandom_range(99);
        if (sel < 10) r = 0;
        else if (sel < 20) r = SUM_MAX;
        else if (sel < 35) r = plan_cum[k];
        else if (sel < 45) r = plan_cum[k] + 1;
        else if (sel < 80) r = $urandom_range(span);
        else r = $urandom;
        if (r > SUM_MAX) r = SUM_MAX;
        queue_draw(SUM_W'(r));
      end else if (sel < 88) begin
        len = $urandom_range(1, (eff < 8) ? eff : 8);
        for (int i = 0; i < len; i++) queue_load(ENTRY_AW'(i), pick_weight());
      end else begin
        queue_load(ENTRY_AW'($urandom_range(MAX_ENTRIES - 1)), pick_weight());
      end
    end
  endtask

  // Hold the sender until every beat is out and every draw is back, then let the core settle.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_draws.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_search_len(input logic [CNT_W-1:0] n);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    search_len = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    logic [CNT_W-1:0] len_setting;
    int               eff;
    int               len;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cum_weight[i]   = '0;
      plan_cum[i]     = '0;
      plan_written[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset search length of one: zero-width first entry, value beyond total,
    // full-scale weight with fraction saturation.
    queue_load(ENTRY_AW'(0), 16'h0000);
    queue_draw(SUM_W'(0));
    queue_draw(SUM_W'(1));
    queue_load(ENTRY_AW'(0), 16'hFFFF);
    queue_draw(SUM_W'(0));
    queue_draw(24'd65535);
    queue_draw(SUM_MAX);
    wait_idle();

    // Four entries with a zero weight inside, then an out-of-order reload.
    write_search_len(CNT_W'(4));
    queue_load(ENTRY_AW'(0), 16'd1);
    queue_load(ENTRY_AW'(1), 16'd0);
    queue_load(ENTRY_AW'(2), 16'd3);
    queue_load(ENTRY_AW'(3), 16'd20);
    queue_draw(SUM_W'(2));
    queue_draw(SUM_W'(24));
    queue_draw(SUM_W'(25));
    queue_load(ENTRY_AW'(0), 16'd5);
    queue_load(ENTRY_AW'(2), 16'd0);
    queue_draw(SUM_W'(4));
    queue_draw(SUM_W'(5));

    // Random phases, each with its own search length and idling pattern.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0:       len_setting = '1;
        1:       len_setting = '0;
        2:       len_setting = CNT_W'(MAX_ENTRIES);
        3:       len_setting = CNT_W'(1);
        4:       len_setting = CNT_W'($urandom_range(2, 20));
        5:       len_setting = CNT_W'($urandom_range(MAX_ENTRIES + 1, 510));
        6:       len_setting = CNT_W'($urandom_range(2, 40));
        default: len_setting = CNT_W'($urandom_range(2, 12));
      endcase
      write_search_len(len_setting);
      eff = clamp_search_len(len_setting);
      send_idle_pct = (p % 4 == 1) ? 78 : (p % 4 == 3) ? 28 : 0;
      stall_pct     = (p % 4 == 2) ? 78 : (p % 4 == 3) ? 28 : 0;

      if (p == 0) begin
        // Full table of heavy weights, then push the running sum into saturation.
        for (int i = 0; i < MAX_ENTRIES; i++)
          queue_load(ENTRY_AW'(i),
                     ($urandom_range(99) < 85) ? 16'hFFFF : WEIGHT_W'($urandom));
        while (plan_sum != SUM_MAX)
          queue_load(ENTRY_AW'($urandom_range(1, MAX_ENTRIES - 1)), 16'hFFFF);
      end else begin
        len = $urandom_range(1, (eff < 24) ? eff : 24);
        for (int i = 0; i < len; i++) queue_load(ENTRY_AW'(i), pick_weight());
      end
      // Never search an entry that has not been loaded.
      for (int i = 0; i < eff; i++)
        if (!plan_written[i]) queue_load(ENTRY_AW'(i), pick_weight());

      queue_random_items(HALF_ITEMS, eff);
      wait_idle();
      queue_random_items(HALF_ITEMS, eff);
    end

    wait_idle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
